// ===== design/swdc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the sliding-window distinct colour counter.
package swdc_pkg;

  // fixed field widths of the channels
  localparam int COLOR_W  = 10;
  localparam int LEN_W    = 11;
  localparam int START_W  = 20;
  localparam int OUTCNT_W = 11;
  localparam int ITEMS_W  = START_W + 1;

  localparam logic [ITEMS_W-1:0] ITEMS_MAX = '1;
  localparam logic [START_W-1:0] START_MAX = '1;

  // result queue
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_LVL_W = $clog2(OUTQ_DEPTH + 1);

  // per-beat control from the accept stage to the count pipeline
  typedef struct packed {
    logic               valid;
    logic               filled;
    logic               emit;
    logic [START_W-1:0] start;
  } issue_t;

  // count store sweep control
  typedef struct packed {
    logic active;
    logic restart;
  } clear_t;

  typedef struct packed {
    logic [START_W-1:0]  window_start;
    logic [OUTCNT_W-1:0] distinct_count;
    logic [OUTCNT_W-1:0] max_distinct;
  } result_t;

endpackage

// ===== design/swdc_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: setup write, colour cells and window results.
interface swdc_cfg_if import swdc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] window_len;

  modport source (output valid, output window_len, input ready);
  modport sink (input valid, input window_len, output ready);
endinterface

interface swdc_color_if import swdc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color;

  modport source (output valid, output color, input ready);
  modport sink (input valid, input color, output ready);
endinterface

interface swdc_result_if import swdc_pkg::*;;
  logic                valid;
  logic                ready;
  logic [START_W-1:0]  window_start;
  logic [OUTCNT_W-1:0] distinct_count;
  logic [OUTCNT_W-1:0] max_distinct;

  modport source (output valid, output window_start, output distinct_count,
                  output max_distinct, input ready);
  modport sink (input valid, input window_start, input distinct_count,
                input max_distinct, output ready);
endinterface

// ===== design/sliding_window_distinct_count.sv =====
`timescale 1ns / 1ps
// Top level of the sliding-window distinct colour counter.
//
// Channels: setup (window_len write), cells (one colour per beat) and
// windows (window_start, distinct_count, max_distinct per beat).
// A setup write takes the new window length and restarts the strip; the
// user must issue it only while no cell is in flight and no result is
// pending; the block itself does not enforce this. Cells are taken one per
// cycle while cells.ready is high. A result passes the s1 and s2 registers
// and the result queue to windows; cells that only fill the first window
// give none. The rate is set by the count stores: each cell reads its own
// colour's counters and, in the next cycle, the oldest colour's, and both
// updates are written back from s2, forwarding over writes in flight.
// After reset and after every setup write the count stores are swept to
// zero, one entry a cycle, with cells.ready low.
// A four-beat result queue absorbs receiver stalls; cells.ready drops when
// queued plus in-flight beats reach four and returns as results drain.
module sliding_window_distinct_count import swdc_pkg::*; #(
  parameter int WINDOW_MAX  = 1024,
  parameter int COLOR_COUNT = 1024
) (
  input logic          clk,
  input logic          rst,
  swdc_cfg_if.sink     setup,
  swdc_color_if.sink   cells,
  swdc_result_if.source windows
);

  localparam int CW = $clog2(COLOR_COUNT);

  issue_t                issue;
  logic [CW-1:0]         issue_color;
  logic [CW-1:0]         old_color;
  clear_t                clr;
  logic [CW-1:0]         clr_addr;
  logic [1:0]            inflight;
  logic                  push;
  result_t               push_data;
  logic [OUTQ_LVL_W-1:0] q_level;
  result_t               out_data;
  logic                  cfg_we;

  // setup writes are always taken
  assign setup.ready = 1'b1;
  assign cfg_we      = setup.valid;

  swdc_front #(
    .WINDOW_MAX  (WINDOW_MAX),
    .COLOR_COUNT (COLOR_COUNT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_len     (setup.window_len),
    .cell_valid  (cells.valid),
    .cell_color  (cells.color),
    .cell_ready  (cells.ready),
    .q_level     (q_level),
    .inflight    (inflight),
    .issue       (issue),
    .issue_color (issue_color),
    .old_color   (old_color),
    .clr         (clr),
    .clr_addr    (clr_addr)
  );

  swdc_update #(
    .WINDOW_MAX  (WINDOW_MAX),
    .COLOR_COUNT (COLOR_COUNT)
  ) u_update (
    .clk         (clk),
    .rst         (rst),
    .issue       (issue),
    .issue_color (issue_color),
    .old_color   (old_color),
    .clr         (clr),
    .clr_addr    (clr_addr),
    .inflight    (inflight),
    .push        (push),
    .push_data   (push_data)
  );

  swdc_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .level     (q_level),
    .out_valid (windows.valid),
    .out_data  (out_data),
    .out_ready (windows.ready)
  );

  assign windows.window_start   = out_data.window_start;
  assign windows.distinct_count = out_data.distinct_count;
  assign windows.max_distinct   = out_data.max_distinct;

endmodule

// ===== design/swdc_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data (read-first).
module swdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/swdc_front.sv =====
`timescale 1ns / 1ps
// Accept stage: window length, strip counters, colour ring and count store sweep.
module swdc_front import swdc_pkg::*; #(
  parameter int WINDOW_MAX  = 1024,
  parameter int COLOR_COUNT = 1024,
  localparam int CW = $clog2(COLOR_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [LEN_W-1:0]      cfg_len,
  input  logic                  cell_valid,
  input  logic [COLOR_W-1:0]    cell_color,
  output logic                  cell_ready,
  input  logic [OUTQ_LVL_W-1:0] q_level,
  input  logic [1:0]            inflight,
  output issue_t                issue,
  output logic [CW-1:0]         issue_color,
  output logic [CW-1:0]         old_color,
  output clear_t                clr,
  output logic [CW-1:0]         clr_addr
);

  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int PW = $clog2(WINDOW_MAX);

  logic [LW-1:0]      len_eff;
  logic [LW-1:0]      len_cfg;
  logic [PW-1:0]      pos;
  logic [PW-1:0]      pos_next;
  logic [LW-1:0]      pos_inc;
  logic [ITEMS_W-1:0] items;
  logic [ITEMS_W-1:0] items_next;
  logic [ITEMS_W-1:0] start_diff;
  logic [ITEMS_W-1:0] len_wide;
  logic [OUTQ_LVL_W-1:0] credit;
  logic               clr_active;
  logic [CW-1:0]      clr_ptr;
  logic               accept;
  logic [CW-1:0]      color_red;

  // fold a colour code into the table by repeated compare and subtract
  function automatic logic [COLOR_W-1:0] color_fold(input logic [COLOR_W-1:0] v);
    logic [COLOR_W-1:0] r;
    r = v;
    for (int k = COLOR_W - 1; k >= 0; k--) begin
      if (32'(r) >= (COLOR_COUNT << k)) begin
        r = r - COLOR_W'(COLOR_COUNT << k);
      end
    end
    return r;
  endfunction

  assign color_red = CW'(color_fold(cell_color));

  // zero means one, long windows clamp to the ring size
  always_comb begin
    if (cfg_len == '0) begin
      len_cfg = LW'(1);
    end else if (32'(cfg_len) > WINDOW_MAX) begin
      len_cfg = LW'(WINDOW_MAX);
    end else begin
      len_cfg = LW'(cfg_len);
    end
  end

  // room for every beat in flight plus the new one
  assign credit     = q_level + OUTQ_LVL_W'(inflight);
  assign cell_ready = !clr_active && (32'(credit) < OUTQ_DEPTH);
  assign accept     = cell_valid && cell_ready;

  // ring position and strip length
  assign pos_inc    = LW'(pos) + LW'(1);
  assign pos_next   = (pos_inc == len_eff) ? '0 : PW'(pos_inc);
  assign len_wide   = ITEMS_W'(len_eff);
  assign items_next = (items == ITEMS_MAX) ? items : items + ITEMS_W'(1);
  assign start_diff = items_next - len_wide;

  always_comb begin
    issue.valid  = accept;
    issue.filled = items >= len_wide;
    issue.emit   = items_next >= len_wide;
    if (start_diff > ITEMS_W'(START_MAX)) begin
      issue.start = START_MAX;
    end else begin
      issue.start = start_diff[START_W-1:0];
    end
  end

  assign issue_color = color_red;

  always_ff @(posedge clk) begin
    if (rst) begin
      len_eff    <= LW'(1);
      pos        <= '0;
      items      <= '0;
      clr_active <= 1'b1;
      clr_ptr    <= '0;
    end else if (cfg_we) begin
      len_eff    <= len_cfg;
      pos        <= '0;
      items      <= '0;
      clr_active <= 1'b1;
      clr_ptr    <= '0;
    end else begin
      if (accept) begin
        pos   <= pos_next;
        items <= items_next;
      end
      // count store sweep, one entry a cycle
      if (clr_active) begin
        clr_ptr <= clr_ptr + CW'(1);
        if (clr_ptr == CW'(COLOR_COUNT - 1)) begin
          clr_active <= 1'b0;
        end
      end
    end
  end

  assign clr.active  = clr_active;
  assign clr.restart = cfg_we;
  assign clr_addr    = clr_ptr;

  // colour ring: oldest colour read out while the new one lands in its slot
  swdc_ram #(
    .WIDTH (CW),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (accept),
    .waddr (pos),
    .wdata (color_red),
    .raddr (pos),
    .rdata (old_color)
  );

  a_pos_in_window: assert property (@(posedge clk) disable iff (rst)
    LW'(pos) < len_eff)
    else $error("ring position beyond window length");

endmodule

// ===== design/swdc_update.sv =====
`timescale 1ns / 1ps
// Count pipeline: add/remove counter stores, forwarding, distinct and maximum.
module swdc_update import swdc_pkg::*; #(
  parameter int WINDOW_MAX  = 1024,
  parameter int COLOR_COUNT = 1024,
  localparam int CW = $clog2(COLOR_COUNT)
) (
  input  logic          clk,
  input  logic          rst,
  input  issue_t        issue,
  input  logic [CW-1:0] issue_color,
  input  logic [CW-1:0] old_color,
  input  clear_t        clr,
  input  logic [CW-1:0] clr_addr,
  output logic [1:0]    inflight,
  output logic          push,
  output result_t       push_data
);

  // counters run modulo 2^NW; their difference is the exact count
  localparam int NW = $clog2(WINDOW_MAX + 1);
  localparam int DW = $clog2(COLOR_COUNT + 1);

  typedef struct packed {
    logic          valid;
    logic [CW-1:0] addr;
    logic [NW-1:0] data;
  } wrec_t;

  localparam wrec_t NO_REC = '0;

  issue_t        s1;
  logic [CW-1:0] s1_color;
  issue_t        s2;
  logic [CW-1:0] s2_color;
  logic [CW-1:0] s2_old;
  logic [NW-1:0] s2_ac;
  logic [NW-1:0] s2_rc;

  logic [NW-1:0] ac_rdata, rc_rdata, ao_rdata, ro_rdata;
  logic [NW-1:0] ac, rc, ao, ro;
  logic [NW-1:0] cnt_c, cnt_o;
  logic          newly, rem, gone, same;

  logic [DW-1:0] distinct, best;
  logic [DW-1:0] d_add, d_new, best_new;

  logic          a_we, r_we;
  logic [CW-1:0] a_waddr, r_waddr;
  logic [NW-1:0] a_wdata, r_wdata;
  wrec_t         wa1, wa2, wr1, wr2;

  // newer record wins over older, both over the RAM word
  function automatic logic [NW-1:0] fwd(input logic [NW-1:0] ram, input logic [CW-1:0] addr,
                                        input wrec_t older, input wrec_t newer);
    logic [NW-1:0] r;
    r = ram;
    if (older.valid && older.addr == addr) begin
      r = older.data;
    end
    if (newer.valid && newer.addr == addr) begin
      r = newer.data;
    end
    return r;
  endfunction

  // pipeline registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
      s2.valid <= 1'b0;
    end else begin
      s1 <= issue;
      s2 <= s1;
    end
    s1_color <= issue_color;
    s2_color <= s1_color;
    s2_old   <= old_color;
    s2_ac    <= ac_rdata;
    s2_rc    <= rc_rdata;
  end

  assign inflight = {1'b0, s1.valid} + {1'b0, s2.valid};

  // port-c words missed the writes held in wa2 and wa1,
  // port-o words only the one held in wa1
  assign ac = fwd(s2_ac, s2_color, wa2, wa1);
  assign rc = fwd(s2_rc, s2_color, wr2, wr1);
  assign ao = fwd(ao_rdata, s2_old, NO_REC, wa1);
  assign ro = fwd(ro_rdata, s2_old, NO_REC, wr1);

  // add the new colour, then take out the oldest one
  assign same  = s2_color == s2_old;
  assign cnt_c = ac - rc;
  assign newly = cnt_c == '0;
  assign cnt_o = ao + NW'(same) - ro;
  assign rem   = s2.filled && (cnt_o != '0);
  assign gone  = rem && (cnt_o == NW'(1));

  assign d_add    = distinct + DW'(newly);
  assign d_new    = (gone && d_add != '0) ? d_add - DW'(1) : d_add;
  assign best_new = (d_new > best) ? d_new : best;

  always_ff @(posedge clk) begin
    if (rst || clr.restart) begin
      distinct <= '0;
      best     <= '0;
    end else if (s2.valid) begin
      distinct <= d_new;
      if (s2.emit) begin
        best <= best_new;
      end
    end
  end

  // write ports: sweep zeroes both stores, otherwise the per-beat update
  assign a_we    = clr.active || s2.valid;
  assign a_waddr = clr.active ? clr_addr : s2_color;
  assign a_wdata = clr.active ? '0 : ac + NW'(1);
  assign r_we    = clr.active || (s2.valid && rem);
  assign r_waddr = clr.active ? clr_addr : s2_old;
  assign r_wdata = clr.active ? '0 : ro + NW'(1);

  // write history for forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      wa1.valid <= 1'b0;
      wa2.valid <= 1'b0;
      wr1.valid <= 1'b0;
      wr2.valid <= 1'b0;
    end else begin
      wa1 <= '{valid: a_we, addr: a_waddr, data: a_wdata};
      wr1 <= '{valid: r_we, addr: r_waddr, data: r_wdata};
      wa2 <= wa1;
      wr2 <= wr1;
    end
  end

  // each store kept twice: one copy read at the new colour, one at the oldest
  swdc_ram #(.WIDTH (NW), .DEPTH (COLOR_COUNT)) u_add_c (
    .clk (clk), .we (a_we), .waddr (a_waddr), .wdata (a_wdata),
    .raddr (issue_color), .rdata (ac_rdata)
  );

  swdc_ram #(.WIDTH (NW), .DEPTH (COLOR_COUNT)) u_add_o (
    .clk (clk), .we (a_we), .waddr (a_waddr), .wdata (a_wdata),
    .raddr (old_color), .rdata (ao_rdata)
  );

  swdc_ram #(.WIDTH (NW), .DEPTH (COLOR_COUNT)) u_rem_c (
    .clk (clk), .we (r_we), .waddr (r_waddr), .wdata (r_wdata),
    .raddr (issue_color), .rdata (rc_rdata)
  );

  swdc_ram #(.WIDTH (NW), .DEPTH (COLOR_COUNT)) u_rem_o (
    .clk (clk), .we (r_we), .waddr (r_waddr), .wdata (r_wdata),
    .raddr (old_color), .rdata (ro_rdata)
  );

  assign push = s2.valid && s2.emit;
  assign push_data = '{window_start:   s2.start,
                       distinct_count: OUTCNT_W'(d_new),
                       max_distinct:   OUTCNT_W'(best_new)};

  a_oldest_present: assert property (@(posedge clk) disable iff (rst)
    s2.valid && s2.filled |-> cnt_o != '0)
    else $error("oldest colour has no count in the window");

  a_window_not_empty: assert property (@(posedge clk) disable iff (rst)
    s2.valid && s2.emit |-> d_new != '0)
    else $error("full window reports no colours");

  a_best_tracks: assert property (@(posedge clk) disable iff (rst)
    s2.valid && s2.emit |=> best >= distinct)
    else $error("maximum fell below current distinct count");

endmodule

// ===== design/swdc_outq.sv =====
`timescale 1ns / 1ps
// Small result queue between the count pipeline and the result channel.
module swdc_outq import swdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  result_t               push_data,
  output logic [OUTQ_LVL_W-1:0] level,
  output logic                  out_valid,
  output result_t               out_data,
  input  logic                  out_ready
);

  result_t               slots [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] head;
  logic [OUTQ_PTR_W-1:0] tail;
  logic                  pop;

  assign out_valid = level != '0;
  assign out_data  = slots[head];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      level <= '0;
    end else begin
      if (push) begin
        tail <= tail + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        head <= head + OUTQ_PTR_W'(1);
      end
      level <= level + OUTQ_LVL_W'(push) - OUTQ_LVL_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (32'(level) < OUTQ_DEPTH) || pop)
    else $error("result queue overflow");

endmodule
